// File: src/sorted_keyed_insert_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted keyed insert table: assertion macros
// Shared concurrent assertion forms for the table's checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEYED_INSERT_TABLE_DEFINES_SVH
`define SORTED_KEYED_INSERT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SKIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skit: check failed");

// Next-cycle implication, disabled during reset
`define SKIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skit: check failed");

`endif

// File: src/skit_pkg.sv
// ----------------------------------------------------------------------------
// skit_pkg
// Types, widths and codes shared by the sorted keyed insert table.
// ----------------------------------------------------------------------------
`default_nettype none

package skit_pkg;

  // Table size and derived widths
  localparam int DEPTH   = 8;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 24;
  localparam int CAT_W    = 2;
  localparam int INIDX_W  = 3;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 3;
  localparam int TALLY_W  = 4;

  // Widths large enough for both the internal and the port view
  localparam int POS_EXT_W   = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int TALLY_EXT_W = (CNT_W > TALLY_W) ? CNT_W : TALLY_W;
  localparam int RD_W        = (CNT_W > INIDX_W) ? CNT_W : INIDX_W;

  // Stream data widths, rounded up to whole bytes
  localparam int IN_BITS      = MODE_W + KEY_W + CAT_W + INIDX_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = STATUS_W + POS_W + KEY_W + CAT_W + TALLY_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_READ   = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CAT_W-1:0] cat;
    logic             ins_en;
  } cell_req_t;

  // Compare flags returned by each cell
  typedef struct packed {
    logic eq;
    logic lt;
    logic cat_eq;
  } cell_stat_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   key;
    logic [CAT_W-1:0]   cat;
    logic [TALLY_W-1:0] tally;
  } result_t;

endpackage

`default_nettype wire

// File: src/skit_cell.sv
// ----------------------------------------------------------------------------
// skit_cell
// One table slot: holds a record, compares it with the request key and
// category, and on insert either holds, takes the new record, or takes its
// left neighbor's record.
// ----------------------------------------------------------------------------
`default_nettype none

module skit_cell (
  input  wire                      clk,
  input  wire skit_pkg::cell_req_t req,
  input  wire                      valid,
  input  wire                      left_lt,
  input  wire [skit_pkg::KEY_W-1:0] left_key,
  input  wire [skit_pkg::CAT_W-1:0] left_cat,
  output logic [skit_pkg::KEY_W-1:0] key_o,
  output logic [skit_pkg::CAT_W-1:0] cat_o,
  output skit_pkg::cell_stat_t     stat
);
  import skit_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [CAT_W-1:0] cat_r;

  // Compares against the broadcast request
  always_comb begin
    stat.eq     = valid && (key_r == req.key);
    stat.lt     = valid && (key_r < req.key);
    stat.cat_eq = valid && (cat_r == req.cat);
  end

  // Insert: smaller keys stay, the first larger or empty slot takes the new record,
  // the rest move up one place
  always_ff @(posedge clk) begin
    if (req.ins_en && !stat.lt) begin
      if (left_lt) begin
        key_r <= req.key;
        cat_r <= req.cat;
      end else begin
        key_r <= left_key;
        cat_r <= left_cat;
      end
    end
  end

  assign key_o = key_r;
  assign cat_o = cat_r;

endmodule

`default_nettype wire

// File: src/sorted_keyed_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_keyed_insert_table
// Table of up to DEPTH records in ascending key order, built as a row of
// slot cells that compare in parallel and shift up on insert.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_tvalid/in_tready with in_tdata = {index, category,
//   key, mode}; each gives exactly one result on out_tvalid/out_tready with
//   out_tdata = {tally, category_out, key_out, position, status}.
//   Modes: insert, lookup by key, read by index, count by category.
// Timing: a request is registered on acceptance; the cells compare and the
//   result is registered in the output register once it is free, which
//   raises out_tvalid.
// Flow: one request is held at a time, so a new request is not taken
//   until the last one is through the cell row; in_tready is low while a
//   request is held and being evaluated in the cell row.
// Stall: a result waits in the output register while out_tready is low;
//   the next request may still be accepted, but it is not evaluated (and
//   the table does not change) until the output register frees up.
// Reset: rst_n (synchronous, active low) empties the table (fill count to
//   zero) and drops any held request and result. Slot contents are not
//   cleared; slots above the fill count are never reported.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_keyed_insert_table (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // in_tdata, low bit up: mode[2], key[24], category[2], index[3], zero fill
  input  wire [skit_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // out_tdata, low bit up: status[3], position[3], key_out[24],
  // category_out[2], tally[4], zero fill
  output logic [skit_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import skit_pkg::*;

  // Request register
  logic               req_valid_r;
  mode_t              mode_r;
  logic [KEY_W-1:0]   key_r;
  logic [CAT_W-1:0]   cat_r;
  logic [INIDX_W-1:0] idx_r;

  logic [CNT_W-1:0]   fill_r;
  logic               out_valid_r;
  result_t            res_r;
  result_t            res_nxt;

  logic               in_acc;
  logic               done;
  logic               ins_commit;

  cell_req_t          creq;
  cell_stat_t         cstat    [DEPTH];
  logic [KEY_W-1:0]   cell_key [DEPTH];
  logic [CAT_W-1:0]   cell_cat [DEPTH];
  logic [DEPTH-1:0]   cell_valid;

  // Reductions over the cell row
  logic               any_eq;
  logic [IDX_W-1:0]   eq_pos;
  logic [IDX_W-1:0]   ins_pos;
  logic [KEY_W-1:0]   eq_key;
  logic [CAT_W-1:0]   eq_cat;
  logic [KEY_W-1:0]   rd_key;
  logic [CAT_W-1:0]   rd_cat;
  logic [CNT_W-1:0]   cat_cnt;
  logic               rd_ok;
  logic               full;

  logic [RD_W-1:0]        idx_ext;
  logic [RD_W-1:0]        fill_rd;
  logic [POS_EXT_W-1:0]   eq_pos_ext;
  logic [POS_EXT_W-1:0]   ins_pos_ext;
  logic [TALLY_EXT_W-1:0] fill_ext;
  logic [TALLY_EXT_W-1:0] fill_inc_ext;
  logic [TALLY_EXT_W-1:0] cnt_ext;

  // Handshakes
  assign in_tready = !req_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign done      = req_valid_r && (!out_valid_r || out_tready);
  assign full      = (fill_r == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_acc) begin
      req_valid_r <= 1'b1;
    end else if (done) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= mode_t'(in_tdata[MODE_W-1:0]);
      key_r  <= in_tdata[MODE_W +: KEY_W];
      cat_r  <= in_tdata[MODE_W+KEY_W +: CAT_W];
      idx_r  <= in_tdata[MODE_W+KEY_W+CAT_W +: INIDX_W];
    end
  end

  // Cell row
  assign ins_commit  = done && (mode_r == MODE_INSERT) && !any_eq && !full;
  assign creq.key    = key_r;
  assign creq.cat    = cat_r;
  assign creq.ins_en = ins_commit;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic             left_lt;
    logic [KEY_W-1:0] left_key;
    logic [CAT_W-1:0] left_cat;

    assign cell_valid[g] = (CNT_W'(g) < fill_r);

    if (g == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_key = '0;
      assign left_cat = '0;
    end else begin : g_body
      assign left_lt  = cstat[g-1].lt;
      assign left_key = cell_key[g-1];
      assign left_cat = cell_cat[g-1];
    end

    skit_cell u_cell (
      .clk      (clk),
      .req      (creq),
      .valid    (cell_valid[g]),
      .left_lt  (left_lt),
      .left_key (left_key),
      .left_cat (left_cat),
      .key_o    (cell_key[g]),
      .cat_o    (cell_cat[g]),
      .stat     (cstat[g])
    );
  end

  // Read index check
  assign idx_ext = RD_W'(idx_r);
  assign fill_rd = RD_W'(fill_r);
  assign rd_ok   = (idx_ext < fill_rd);

  // First match, insert slot, read select and category count
  always_comb begin
    any_eq  = 1'b0;
    eq_pos  = '0;
    ins_pos = '0;
    eq_key  = '0;
    eq_cat  = '0;
    rd_key  = '0;
    rd_cat  = '0;
    cat_cnt = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cstat[i].eq) begin
        any_eq = 1'b1;
        eq_pos = IDX_W'(i);
        eq_key = cell_key[i];
        eq_cat = cell_cat[i];
      end
      if (!cstat[i].lt) begin
        ins_pos = IDX_W'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (RD_W'(i) == idx_ext) begin
        rd_key = cell_key[i];
        rd_cat = cell_cat[i];
      end
      cat_cnt = cat_cnt + CNT_W'(cstat[i].cat_eq);
    end
  end

  assign eq_pos_ext   = POS_EXT_W'(eq_pos);
  assign ins_pos_ext  = POS_EXT_W'(ins_pos);
  assign fill_ext     = TALLY_EXT_W'(fill_r);
  assign fill_inc_ext = TALLY_EXT_W'(fill_r) + TALLY_EXT_W'(1);
  assign cnt_ext      = TALLY_EXT_W'(cat_cnt);

  // Result selection
  always_comb begin
    res_nxt.status   = ST_NOT_FOUND;
    res_nxt.position = '0;
    res_nxt.key      = '0;
    res_nxt.cat      = '0;
    res_nxt.tally    = fill_ext[TALLY_W-1:0];
    unique case (mode_r)
      MODE_INSERT: begin
        if (any_eq) begin
          res_nxt.status   = ST_DUPLICATE;
          res_nxt.position = eq_pos_ext[POS_W-1:0];
          res_nxt.key      = eq_key;
          res_nxt.cat      = eq_cat;
        end else if (full) begin
          res_nxt.status   = ST_FULL;
        end else begin
          res_nxt.status   = ST_INSERTED;
          res_nxt.position = ins_pos_ext[POS_W-1:0];
          res_nxt.key      = key_r;
          res_nxt.cat      = cat_r;
          res_nxt.tally    = fill_inc_ext[TALLY_W-1:0];
        end
      end
      MODE_LOOKUP: begin
        if (any_eq) begin
          res_nxt.status   = ST_FOUND;
          res_nxt.position = eq_pos_ext[POS_W-1:0];
          res_nxt.key      = eq_key;
          res_nxt.cat      = eq_cat;
        end
      end
      MODE_READ: begin
        if (rd_ok) begin
          res_nxt.status   = ST_FOUND;
          res_nxt.position = idx_r;
          res_nxt.key      = rd_key;
          res_nxt.cat      = rd_cat;
        end else begin
          res_nxt.status   = ST_BAD_INDEX;
        end
      end
      MODE_COUNT: begin
        res_nxt.status = (cat_cnt != '0) ? ST_FOUND : ST_NOT_FOUND;
        res_nxt.tally  = cnt_ext[TALLY_W-1:0];
      end
      default: begin
        res_nxt.status = ST_NOT_FOUND;
      end
    endcase
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ins_commit) begin
      fill_r <= fill_r + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({res_r.tally, res_r.cat, res_r.key,
                                    res_r.position, res_r.status});

endmodule

`default_nettype wire

// File: src/skit_chk.sv
// ----------------------------------------------------------------------------
// skit_chk
// Port-level checks for the sorted keyed insert table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_keyed_insert_table_defines.svh"

module skit_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [skit_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import skit_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [POS_W-1:0]    pos;
  logic [CAT_W-1:0]    cat;

  assign st  = out_tdata[STATUS_W-1:0];
  assign pos = out_tdata[STATUS_W +: POS_W];
  assign cat = out_tdata[STATUS_W+POS_W+KEY_W +: CAT_W];

  // A stalled result holds
  `SKIT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Only one request is in flight
  `SKIT_ASSERT_NEXT(a_one_req, in_tvalid && in_tready, !in_tready)

  // Status codes stay in range
  `SKIT_ASSERT_NOW(a_status_rng, out_tvalid, st <= ST_BAD_INDEX)

  // Miss, full and bad index report no record
  `SKIT_ASSERT_NOW(a_miss_zero,
    out_tvalid && (st == ST_NOT_FOUND || st == ST_FULL || st == ST_BAD_INDEX),
    pos == '0 && cat == '0)

endmodule

bind sorted_keyed_insert_table skit_chk u_skit_chk (.*);

`default_nettype wire
